>>> rtl/core/worst_fit_partition_allocator_unit_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both forms sample on aclk and are held off while aresetn is low.
`ifndef WORST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define WORST_FIT_PARTITION_ALLOCATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define WFPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WFPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/wfpa_pkg.sv
`default_nettype none

package wfpa_pkg;

    // Default configuration
    localparam int NUM_SLOTS_DEF   = 32;
    localparam int ADDR_BITS_DEF   = 16;
    localparam int JOB_ID_BITS_DEF = 8;

    // Stream field widths
    localparam int MODE_W   = 2;
    localparam int JOB_W    = 8;
    localparam int START_W  = 16;
    localparam int AMT_W    = 17;
    localparam int STATUS_W = 3;

    // Input tdata layout, lowest field first
    localparam int IN_JOB_LSB    = 0;
    localparam int IN_START_LSB  = IN_JOB_LSB + JOB_W;
    localparam int IN_AMT_LSB    = IN_START_LSB + START_W;
    localparam int IN_FIELDS_W   = IN_AMT_LSB + AMT_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first
    localparam int OUT_FIELDS_W  = START_W + AMT_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOJOB = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD   = 3'd4;

    // Follow-up chosen by the datapath once the first scan is done
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_SPLIT = 2'd1,
        ACT_NSCAN = 2'd2
    } act_t;

    // Controller to datapath strobes
    typedef struct packed {
        logic latch;
        logic issue;
        logic nb_scan;
        logic decide;
        logic split;
        logic free_wr;
        logic push;
    } wfpa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        act_t act;
        logic out_busy;
    } wfpa_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/wfpa_ctrl.sv
`default_nettype none

`include "worst_fit_partition_allocator_unit_macros.svh"

module wfpa_ctrl import wfpa_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int IW = $clog2(NUM_SLOTS)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire wfpa_sts_t     sts,
    output wfpa_cmd_t          cmd,
    output logic [IW-1:0]      cmd_idx
);

    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SCAN      = 9'b000000010,
        ST_SCAN_END  = 9'b000000100,
        ST_DECIDE    = 9'b000001000,
        ST_SPLIT     = 9'b000010000,
        ST_NSCAN     = 9'b000100000,
        ST_NSCAN_END = 9'b001000000,
        ST_FREE_WR   = 9'b010000000,
        ST_PUSH      = 9'b100000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    // Sequence one request: scan, decide, for a free scan for neighbours, write back, hand over the result
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_SCAN_END;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                unique case (sts.act)
                    ACT_SPLIT: state_next = ST_SPLIT;
                    ACT_NSCAN: begin
                        idx_next   = '0;
                        state_next = ST_NSCAN;
                    end
                    default:   state_next = ST_PUSH;
                endcase
            end
            ST_SPLIT: begin
                cmd.split  = 1'b1;
                state_next = ST_PUSH;
            end
            ST_NSCAN: begin
                cmd.issue   = 1'b1;
                cmd.nb_scan = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_NSCAN_END;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_NSCAN_END: begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                cmd.free_wr = 1'b1;
                state_next  = ST_PUSH;
            end
            ST_PUSH: begin
                if (!sts.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cmd_idx = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `WFPA_ASSERT_NEXT(a_accept_starts_scan, s_tvalid && s_tready, (state_reg == ST_SCAN) && (idx_reg == '0), "accepted transfer did not start a scan at slot zero")
    `WFPA_ASSERT_NEXT(a_scan_index_steps, ((state_reg == ST_SCAN) || (state_reg == ST_NSCAN)) && (idx_reg != LAST_IDX), idx_reg == $past(idx_reg) + 1'b1, "scan index skipped a slot")
    `WFPA_ASSERT_SAME(a_free_after_nscan, state_reg == ST_FREE_WR, $past(state_reg) == ST_NSCAN_END, "free write without a neighbour scan")

endmodule

`default_nettype wire

>>> rtl/core/wfpa_dpath.sv
`default_nettype none

`include "worst_fit_partition_allocator_unit_macros.svh"

module wfpa_dpath import wfpa_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int JOB_ID_BITS = JOB_ID_BITS_DEF,
    localparam int IW = $clog2(NUM_SLOTS)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire wfpa_cmd_t                cmd,
    input  wire logic [IW-1:0]            cmd_idx,
    output wfpa_sts_t                     sts,
    input  wire logic [IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [MODE_W-1:0]        s_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata,
    output logic [STATUS_W-1:0]           m_tuser
);

    localparam int AW = ADDR_BITS;
    localparam int SW = ADDR_BITS + 1;
    localparam int JW = JOB_ID_BITS;
    localparam int LW = ((AW > AMT_W) ? AW : AMT_W) + 1;

    // Slot table: one write port, one registered read port
    logic          mem_free  [NUM_SLOTS];
    logic [JW-1:0] mem_owner [NUM_SLOTS];
    logic [SW-1:0] mem_size  [NUM_SLOTS];
    logic [AW-1:0] mem_start [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] valid_reg;

    // Latched request
    logic [MODE_W-1:0] mode_reg;
    logic [JW-1:0]     job_reg;
    logic [AW-1:0]     start_reg;
    logic [AMT_W-1:0]  amount_reg;

    // Read pipeline
    logic          rd_free_reg;
    logic [JW-1:0] rd_owner_reg;
    logic [SW-1:0] rd_size_reg;
    logic [AW-1:0] rd_start_reg;
    logic [IW-1:0] idx_d_reg;
    logic          eval_reg, eval_nb_reg;

    // Scan trackers
    logic          empty_found_reg, best_found_reg, cur_found_reg, l_found_reg, r_found_reg;
    logic [IW-1:0] empty_idx_reg, best_idx_reg, cur_idx_reg, l_idx_reg, r_idx_reg;
    logic [SW-1:0] best_size_reg, cur_size_reg, l_size_reg, r_size_reg;
    logic [AW-1:0] best_start_reg, cur_start_reg, l_start_reg;

    // Result waiting for the output register
    logic [STATUS_W-1:0] res_status_reg;
    logic [AW-1:0]       res_start_reg;
    logic [SW-1:0]       res_size_reg;

    // Output register
    logic                      m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [STATUS_W-1:0]       m_tuser_reg;

    // Per-entry comparisons
    logic          rd_valid;
    logic          hit_empty, hit_best, hit_cur, nb_cand, hit_left, hit_right;
    logic [SW-1:0] rd_end, cur_end;

    // Decision and write-back
    logic [STATUS_W-1:0] dec_status;
    act_t                dec_act;
    logic [AW-1:0]       dec_start;
    logic [SW-1:0]       dec_size;
    logic                dec_wr, dec_vset;
    logic [IW-1:0]       dec_idx;
    logic                dec_free;
    logic [JW-1:0]       dec_owner;
    logic [SW-1:0]       dec_wsize;
    logic [AW-1:0]       dec_wstart;
    logic                load_bad;

    logic          wr_en, vset_en, vclr_cur_en, vclr_r_en;
    logic [IW-1:0] wr_idx;
    logic          wr_free;
    logic [JW-1:0] wr_owner;
    logic [SW-1:0] wr_size;
    logic [AW-1:0] wr_start;

    // Evaluate the entry read in the previous cycle
    always_comb begin
        rd_valid  = valid_reg[idx_d_reg];
        rd_end    = SW'(rd_start_reg) + rd_size_reg;
        cur_end   = SW'(cur_start_reg) + cur_size_reg;
        hit_empty = !rd_valid && !empty_found_reg;
        hit_best  = rd_valid && rd_free_reg &&
                    (!best_found_reg || (rd_size_reg > best_size_reg) ||
                     ((rd_size_reg == best_size_reg) && (rd_start_reg < best_start_reg)));
        hit_cur   = rd_valid && !rd_free_reg && (rd_owner_reg == job_reg) &&
                    (!cur_found_reg || (rd_start_reg < cur_start_reg));
        nb_cand   = rd_valid && rd_free_reg && (idx_d_reg != cur_idx_reg);
        hit_left  = nb_cand && !l_found_reg && (rd_end == SW'(cur_start_reg));
        hit_right = nb_cand && !r_found_reg && (SW'(rd_start_reg) == cur_end);
    end

    // Choose the outcome of the first scan
    always_comb begin
        load_bad   = (amount_reg == '0) ||
                     ((LW'(start_reg) + LW'(amount_reg)) > (LW'(1) << AW));
        dec_status = ST_BAD;
        dec_act    = ACT_PUSH;
        dec_start  = '0;
        dec_size   = '0;
        dec_wr     = 1'b0;
        dec_vset   = 1'b0;
        dec_idx    = empty_idx_reg;
        dec_free   = 1'b0;
        dec_owner  = job_reg;
        dec_wsize  = SW'(amount_reg);
        dec_wstart = best_start_reg;
        unique case (mode_reg)
            MODE_LOAD: begin
                if (load_bad) begin
                    dec_status = ST_BAD;
                end else if (!empty_found_reg) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_status = ST_OK;
                    dec_start  = start_reg;
                    dec_size   = SW'(amount_reg);
                    dec_wr     = 1'b1;
                    dec_vset   = 1'b1;
                    dec_free   = 1'b1;
                    dec_owner  = '0;
                    dec_wstart = start_reg;
                end
            end
            MODE_ALLOC: begin
                if (amount_reg == '0) begin
                    dec_status = ST_BAD;
                end else if (!best_found_reg ||
                             (LW'(best_size_reg) < LW'(amount_reg))) begin
                    dec_status = ST_NOFIT;
                end else if (LW'(best_size_reg) == LW'(amount_reg)) begin
                    // exact fit: take over the whole slot
                    dec_status = ST_OK;
                    dec_start  = best_start_reg;
                    dec_size   = best_size_reg;
                    dec_wr     = 1'b1;
                    dec_idx    = best_idx_reg;
                    dec_wsize  = best_size_reg;
                end else if (!empty_found_reg) begin
                    dec_status = ST_FULL;
                end else begin
                    // carve from the low end, shrink the region next cycle
                    dec_status = ST_OK;
                    dec_act    = ACT_SPLIT;
                    dec_start  = best_start_reg;
                    dec_size   = SW'(amount_reg);
                    dec_wr     = 1'b1;
                    dec_vset   = 1'b1;
                end
            end
            MODE_FREE: begin
                if (!cur_found_reg) begin
                    dec_status = ST_NOJOB;
                end else begin
                    dec_status = ST_OK;
                    dec_act    = ACT_NSCAN;
                    dec_start  = cur_start_reg;
                    dec_size   = cur_size_reg;
                end
            end
            default: begin
                dec_status = ST_BAD;
            end
        endcase
    end

    // Select the table write for the current step
    always_comb begin
        wr_en       = 1'b0;
        vset_en     = 1'b0;
        vclr_cur_en = 1'b0;
        vclr_r_en   = 1'b0;
        wr_idx      = dec_idx;
        wr_free     = dec_free;
        wr_owner    = dec_owner;
        wr_size     = dec_wsize;
        wr_start    = dec_wstart;
        priority if (cmd.decide) begin
            wr_en   = dec_wr;
            vset_en = dec_vset;
        end else if (cmd.split) begin
            wr_en    = 1'b1;
            wr_idx   = best_idx_reg;
            wr_free  = 1'b1;
            wr_owner = '0;
            wr_size  = best_size_reg - SW'(amount_reg);
            wr_start = AW'(SW'(best_start_reg) + SW'(amount_reg));
        end else if (cmd.free_wr) begin
            // merged region keeps the lower neighbour's slot when there is one
            wr_en       = 1'b1;
            wr_idx      = l_found_reg ? l_idx_reg : cur_idx_reg;
            wr_free     = 1'b1;
            wr_owner    = '0;
            wr_size     = (l_found_reg ? l_size_reg : SW'(0)) + cur_size_reg +
                          (r_found_reg ? r_size_reg : SW'(0));
            wr_start    = l_found_reg ? l_start_reg : cur_start_reg;
            vclr_cur_en = l_found_reg;
            vclr_r_en   = r_found_reg;
        end else begin
            wr_en = 1'b0;
        end
    end

    // Table write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_free[wr_idx]  <= wr_free;
            mem_owner[wr_idx] <= wr_owner;
            mem_size[wr_idx]  <= wr_size;
            mem_start[wr_idx] <= wr_start;
        end
    end

    // Table read port
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_free_reg  <= mem_free[cmd_idx];
            rd_owner_reg <= mem_owner[cmd_idx];
            rd_size_reg  <= mem_size[cmd_idx];
            rd_start_reg <= mem_start[cmd_idx];
        end
        idx_d_reg <= cmd_idx;
    end

    // Slot valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (vset_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (vclr_cur_en) begin
                valid_reg[cur_idx_reg] <= 1'b0;
            end
            if (vclr_r_en) begin
                valid_reg[r_idx_reg] <= 1'b0;
            end
        end
    end

    // Latch the request and track the scans
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_reg        <= 1'b0;
            eval_nb_reg     <= 1'b0;
            empty_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            cur_found_reg   <= 1'b0;
            l_found_reg     <= 1'b0;
            r_found_reg     <= 1'b0;
        end else begin
            eval_reg    <= cmd.issue;
            eval_nb_reg <= cmd.nb_scan;
            if (cmd.latch) begin
                mode_reg        <= s_tuser;
                job_reg         <= JW'(s_tdata[IN_JOB_LSB +: JOB_W]);
                start_reg       <= AW'(s_tdata[IN_START_LSB +: START_W]);
                amount_reg      <= s_tdata[IN_AMT_LSB +: AMT_W];
                empty_found_reg <= 1'b0;
                best_found_reg  <= 1'b0;
                cur_found_reg   <= 1'b0;
            end
            if (cmd.decide) begin
                l_found_reg <= 1'b0;
                r_found_reg <= 1'b0;
            end
            if (eval_reg && !eval_nb_reg) begin
                if (hit_empty) begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= idx_d_reg;
                end
                if (hit_best) begin
                    best_found_reg <= 1'b1;
                    best_idx_reg   <= idx_d_reg;
                    best_size_reg  <= rd_size_reg;
                    best_start_reg <= rd_start_reg;
                end
                if (hit_cur) begin
                    cur_found_reg <= 1'b1;
                    cur_idx_reg   <= idx_d_reg;
                    cur_size_reg  <= rd_size_reg;
                    cur_start_reg <= rd_start_reg;
                end
            end
            if (eval_reg && eval_nb_reg) begin
                if (hit_left) begin
                    l_found_reg <= 1'b1;
                    l_idx_reg   <= idx_d_reg;
                    l_size_reg  <= rd_size_reg;
                    l_start_reg <= rd_start_reg;
                end
                if (hit_right) begin
                    r_found_reg <= 1'b1;
                    r_idx_reg   <= idx_d_reg;
                    r_size_reg  <= rd_size_reg;
                end
            end
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            res_status_reg <= dec_status;
            res_start_reg  <= dec_start;
            res_size_reg   <= dec_size;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                m_tvalid_reg <= 1'b1;
                m_tuser_reg  <= res_status_reg;
                m_tdata_reg  <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                                 AMT_W'(res_size_reg), START_W'(res_start_reg)};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;
    assign sts.act      = dec_act;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    `WFPA_ASSERT_NEXT(a_error_fields_zero, cmd.push && (res_status_reg != ST_OK), m_tdata == '0, "error result carries a non-zero partition")
    `WFPA_ASSERT_SAME(a_decide_write_ok, cmd.decide && wr_en, dec_status == ST_OK, "table written on a failed request")
    `WFPA_ASSERT_NEXT(a_merge_drops_slot, cmd.free_wr && l_found_reg, !valid_reg[cur_idx_reg], "freed slot still valid after merge into lower neighbour")

endmodule

`default_nettype wire

>>> rtl/core/worst_fit_partition_allocator_unit.sv
`default_nettype none

// Worst-fit partition allocator. Each input transfer carries a request in
// s_tuser (0 load a free region, 1 allocate for a job, 2 free a job's lowest
// partition) and returns exactly one result transfer with a status code in
// m_tuser and the partition start and size in m_tdata (zero on any error).
// The table of NUM_SLOTS partitions sits in a single-port-read memory, so
// every request first reads all slots one per cycle; an allocation that
// splits a region writes the shrunk remainder in an extra step, and a
// successful free reads the table a second time to find neighbours to
// merge with. One request is in flight at a time; a finished result waits
// in the output register and the next request is taken while it does.
// Slot valid bits clear at reset, so no clearing pass.

module worst_fit_partition_allocator_unit import wfpa_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF,
    parameter int JOB_ID_BITS = JOB_ID_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // job_id, region_start, amount
    input  wire logic [MODE_W-1:0]      s_tuser,   // mode
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // granted_start, granted_size
    output logic [STATUS_W-1:0]         m_tuser    // status
);

    localparam int IW = $clog2(NUM_SLOTS);

    wfpa_cmd_t     cmd;
    wfpa_sts_t     sts;
    logic [IW-1:0] cmd_idx;

    wfpa_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .cmd_idx  (cmd_idx)
    );

    wfpa_dpath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .ADDR_BITS   (ADDR_BITS),
        .JOB_ID_BITS (JOB_ID_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cmd_idx  (cmd_idx),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
